[rtl/core/tpbs_pkg.sv]
package tpbs_pkg;

   // Beacon timing, in milliseconds
   localparam int BEACON_PERIOD = 1200;
   localparam int FADE_LENGTH   = 200;

   localparam logic [15:0] PERIOD_VAL = 16'(BEACON_PERIOD);
   localparam logic [15:0] FADE_VAL   = 16'(FADE_LENGTH);

   // Bit-serial divider: 32-bit dividend, 16-bit divisor, one bit per cycle
   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      OP_SCAN     = 2'd0,
      OP_SET_MODE = 2'd1,
      OP_ATTACH   = 2'd2,
      OP_DETACH   = 2'd3
   } tpbs_op_type;

   typedef enum logic [1:0] {
      MODE_DISABLED = 2'd0,
      MODE_GUIDANCE = 2'd1,
      MODE_LANDED   = 2'd2
   } tpbs_mode_type;

   typedef enum logic [1:0] {
      ANIM_OFF   = 2'd0,
      ANIM_GUIDE = 2'd1,
      ANIM_FADE  = 2'd2
   } tpbs_anim_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GMOD_GO,
      ST_GMOD_WAIT,
      ST_GSCALE_GO,
      ST_GSCALE_WAIT,
      ST_GMUL_LO,
      ST_GMUL_HI,
      ST_GINTERP_GO,
      ST_GINTERP_WAIT,
      ST_FADE_CHECK,
      ST_FADE_MUL,
      ST_FADE_GO,
      ST_FADE_WAIT,
      ST_DONE
   } tpbs_state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } tpbs_div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
      logic [15:0] remainder;
   } tpbs_div_rsp_type;

   // Quarter sine wave in Q1.15, 32768 = 1.0
   localparam logic [15:0] SINE_QUARTER [33] = '{
      16'd0,     16'd1608,  16'd3212,  16'd4808,  16'd6393,  16'd7962,
      16'd9512,  16'd11039, 16'd12540, 16'd14010, 16'd15447, 16'd16846,
      16'd18205, 16'd19520, 16'd20788, 16'd22006, 16'd23170, 16'd24279,
      16'd25330, 16'd26320, 16'd27246, 16'd28106, 16'd28899, 16'd29622,
      16'd30274, 16'd30853, 16'd31357, 16'd31786, 16'd32138, 16'd32413,
      16'd32610, 16'd32729, 16'd32768
   };

   // Half sine wave over 0..64, zero at and past 64
   function automatic logic [15:0] half_wave_at(input logic [6:0] k);
      logic [5:0] k6;
      logic [6:0] mirror;
      k6     = k[5:0];
      mirror = 7'd64 - {1'b0, k6};
      if (k[6]) begin
         return 16'd0;
      end else if (k6 <= 6'd32) begin
         return SINE_QUARTER[k6];
      end else begin
         return SINE_QUARTER[mirror[5:0]];
      end
   endfunction

endpackage

[rtl/core/tpbs_req_if.sv]
interface tpbs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [1:0]  mode_request;
   logic [31:0] now_ms;

   modport source (output valid, output opcode, output mode_request, output now_ms,
                   input ready);
   modport sink   (input valid, input opcode, input mode_request, input now_ms,
                   output ready);
endinterface

[rtl/core/tpbs_rsp_if.sv]
interface tpbs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pwm_a;
   logic [7:0] pwm_b;
   logic [1:0] anim_phase;
   logic       is_attached;

   modport source (output valid, output pwm_a, output pwm_b, output anim_phase,
                   output is_attached, input ready);
   modport sink   (input valid, input pwm_a, input pwm_b, input anim_phase,
                   input is_attached, output ready);
endinterface

[rtl/core/tpbs_serdiv.sv]
module tpbs_serdiv
   import tpbs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  tpbs_div_req_type div_req,
   output tpbs_div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]          quo_ff, quo_in;
   logic [15:0]          rem_ff, rem_in;
   logic [15:0]          divisor_ff, divisor_in;
   logic [16:0]          trial;
   logic [16:0]          diff;
   logic                 fits;

   // Shift one dividend bit into the partial remainder, subtract if it fits
   assign trial = {rem_ff, quo_ff[31]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         quo_in     = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], fits};
         rem_in = fits ? diff[15:0] : trial[15:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff     <= cnt_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

[rtl/core/two_pair_led_beacon_sequencer.sv]
// Two-pair LED beacon sequencer. Each request item carries a command (scan, set mode,
// attach, detach) and a millisecond timestamp, and yields exactly one response item
// with the PWM levels of pairs A and B, the animation phase and the attach flag,
// all as they stand after the command. Commands that only change state pass through
// ST_DONE into the output register. A guidance scan, or switching to landed from
// guidance, runs three divisions on the shared bit-serial divider (period remainder,
// sine table position, interpolation) and two multiply steps. A fade scan runs two
// divisions by the fade length. The divider retires one quotient bit per cycle over
// 32 bits. One item is worked on at a time; the next item may be accepted while the
// previous response still waits to be taken.
module two_pair_led_beacon_sequencer
   import tpbs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   tpbs_req_if.sink          req,
   tpbs_rsp_if.source        rsp
);

   tpbs_state_type   state_ff, state_in;
   logic             attached_ff, attached_in;
   tpbs_anim_type    anim_ff, anim_in;
   logic [31:0]      guide_start_ff, guide_start_in;
   logic [31:0]      fade_start_ff, fade_start_in;
   logic [15:0]      fade_from_a_ff, fade_from_a_in;
   logic [15:0]      fade_from_b_ff, fade_from_b_in;
   logic [15:0]      duty_a_ff, duty_a_in;
   logic [15:0]      duty_b_ff, duty_b_in;
   logic [31:0]      now_ff, now_in;
   logic             landing_ff, landing_in;
   logic             pair_b_ff, pair_b_in;
   logic             sel_b_ff, sel_b_in;
   logic [15:0]      x_ff, x_in;
   logic [15:0]      f_ff, f_in;
   logic [15:0]      lo_ff, lo_in;
   logic [15:0]      hi_ff, hi_in;
   logic [31:0]      acc_ff, acc_in;
   logic [31:0]      mul_ff, mul_in;
   logic [15:0]      lenme_ff, lenme_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       pwm_a_ff, pwm_a_in;
   logic [7:0]       pwm_b_ff, pwm_b_in;
   logic [1:0]       phase_ff, phase_in;
   logic             att_out_ff, att_out_in;

   tpbs_div_req_type div_req;
   tpbs_div_rsp_type div_rsp;

   logic             req_fire;
   logic [16:0]      x2;
   logic [16:0]      x2_sub;
   logic             x2_ge;
   logic [6:0]       q7;
   logic [6:0]       q7_next;
   logic [31:0]      elapsed;
   logic [15:0]      len_left;
   logic [15:0]      mul_a;
   logic [15:0]      mul_b;
   logic [31:0]      mul_prod;
   logic [15:0]      pulse;
   logic [23:0]      pwm_a_prod;
   logic [23:0]      pwm_b_prod;
   logic             rsp_free;

   tpbs_serdiv u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_fire = req.valid && req.ready;
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   // Guidance half-period split and table position
   assign x2      = {div_rsp.remainder, 1'b0};
   assign x2_ge   = (x2 >= {1'b0, PERIOD_VAL});
   assign x2_sub  = x2 - {1'b0, PERIOD_VAL};
   assign q7      = {1'b0, div_rsp.quotient[5:0]};
   assign q7_next = q7 + 7'd1;
   assign pulse   = div_rsp.quotient[15:0];

   // Fade elapsed time
   assign elapsed  = now_ff - fade_start_ff;
   assign len_left = FADE_VAL - elapsed[15:0];

   // Shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_GMUL_LO: begin
            mul_a = lo_ff;
            mul_b = PERIOD_VAL - f_ff;
         end
         ST_GMUL_HI: begin
            mul_a = hi_ff;
            mul_b = f_ff;
         end
         ST_FADE_MUL: begin
            mul_a = sel_b_ff ? fade_from_b_ff : fade_from_a_ff;
            mul_b = lenme_ff;
         end
         default: begin
         end
      endcase
   end
   assign mul_prod = mul_a * mul_b;

   // Divider operands per step
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = PERIOD_VAL;
      unique case (state_ff)
         ST_GMOD_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = now_ff - guide_start_ff;
         end
         ST_GSCALE_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = 32'({x_ff, 6'b0});
         end
         ST_GINTERP_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = acc_ff + mul_ff;
         end
         ST_FADE_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = mul_ff;
            div_req.divisor  = FADE_VAL;
         end
         default: begin
         end
      endcase
   end

   // PWM is the truncated duty * 255 in Q1.15
   assign pwm_a_prod = 24'(duty_a_ff) * 24'd255;
   assign pwm_b_prod = 24'(duty_b_ff) * 24'd255;

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in       = state_ff;
      attached_in    = attached_ff;
      anim_in        = anim_ff;
      guide_start_in = guide_start_ff;
      fade_start_in  = fade_start_ff;
      fade_from_a_in = fade_from_a_ff;
      fade_from_b_in = fade_from_b_ff;
      duty_a_in      = duty_a_ff;
      duty_b_in      = duty_b_ff;
      now_in         = now_ff;
      landing_in     = landing_ff;
      pair_b_in      = pair_b_ff;
      sel_b_in       = sel_b_ff;
      x_in           = x_ff;
      f_in           = f_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      acc_in         = acc_ff;
      mul_in         = mul_ff;
      lenme_in       = lenme_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      pwm_a_in       = pwm_a_ff;
      pwm_b_in       = pwm_b_ff;
      phase_in       = phase_ff;
      att_out_in     = att_out_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               now_in     = req.now_ms;
               landing_in = 1'b0;
               state_in   = ST_DONE;
               priority if (tpbs_op_type'(req.opcode) == OP_ATTACH) begin
                  guide_start_in = req.now_ms;
                  fade_start_in  = '0;
                  attached_in    = 1'b1;
                  anim_in        = ANIM_OFF;
                  duty_a_in      = '0;
                  duty_b_in      = '0;
               end else if (!attached_ff) begin
                  // detached: ignore the command
               end else if (tpbs_op_type'(req.opcode) == OP_DETACH) begin
                  attached_in = 1'b0;
                  anim_in     = ANIM_OFF;
                  duty_a_in   = '0;
                  duty_b_in   = '0;
               end else if (tpbs_op_type'(req.opcode) == OP_SET_MODE) begin
                  unique case (tpbs_mode_type'(req.mode_request))
                     MODE_GUIDANCE: begin
                        guide_start_in = req.now_ms;
                        anim_in        = ANIM_GUIDE;
                     end
                     MODE_LANDED: begin
                        priority if (anim_ff == ANIM_GUIDE) begin
                           landing_in = 1'b1;
                           state_in   = ST_GMOD_GO;
                        end else if (anim_ff != ANIM_FADE) begin
                           anim_in   = ANIM_OFF;
                           duty_a_in = '0;
                           duty_b_in = '0;
                        end else begin
                           // hold the running fade
                        end
                     end
                     default: begin
                        anim_in   = ANIM_OFF;
                        duty_a_in = '0;
                        duty_b_in = '0;
                     end
                  endcase
               end else begin
                  // scan
                  priority if (anim_ff == ANIM_GUIDE) begin
                     state_in = ST_GMOD_GO;
                  end else if (anim_ff == ANIM_FADE) begin
                     state_in = ST_FADE_CHECK;
                  end else begin
                     // off: nothing to update
                  end
               end
            end
         end

         ST_GMOD_GO: begin
            state_in = ST_GMOD_WAIT;
         end

         // Pick the pair and its position inside the half period
         ST_GMOD_WAIT: begin
            if (div_rsp.done) begin
               pair_b_in = x2_ge;
               x_in      = x2_ge ? x2_sub[15:0] : x2[15:0];
               state_in  = ST_GSCALE_GO;
            end
         end

         ST_GSCALE_GO: begin
            state_in = ST_GSCALE_WAIT;
         end

         // Look up the two table neighbors and the fraction between them
         ST_GSCALE_WAIT: begin
            if (div_rsp.done) begin
               lo_in    = half_wave_at(q7);
               hi_in    = half_wave_at(q7_next);
               f_in     = div_rsp.remainder;
               state_in = ST_GMUL_LO;
            end
         end

         ST_GMUL_LO: begin
            mul_in   = mul_prod;
            state_in = ST_GMUL_HI;
         end

         ST_GMUL_HI: begin
            acc_in   = mul_ff;
            mul_in   = mul_prod;
            state_in = ST_GINTERP_GO;
         end

         ST_GINTERP_GO: begin
            state_in = ST_GINTERP_WAIT;
         end

         // Store the pulse; capture it as the fade origin when landing, or go off at zero
         ST_GINTERP_WAIT: begin
            if (div_rsp.done) begin
               duty_a_in = pair_b_ff ? 16'd0 : pulse;
               duty_b_in = pair_b_ff ? pulse : 16'd0;
               if (landing_ff) begin
                  fade_start_in  = now_ff;
                  fade_from_a_in = pair_b_ff ? 16'd0 : pulse;
                  fade_from_b_in = pair_b_ff ? pulse : 16'd0;
                  if (pulse == 16'd0) begin
                     anim_in   = ANIM_OFF;
                     duty_a_in = '0;
                     duty_b_in = '0;
                  end else begin
                     anim_in = ANIM_FADE;
                  end
               end
               state_in = ST_DONE;
            end
         end

         // End the fade once its length has gone by
         ST_FADE_CHECK: begin
            if (elapsed >= 32'(FADE_LENGTH)) begin
               anim_in   = ANIM_OFF;
               duty_a_in = '0;
               duty_b_in = '0;
               state_in  = ST_DONE;
            end else begin
               lenme_in = len_left;
               sel_b_in = 1'b0;
               state_in = ST_FADE_MUL;
            end
         end

         ST_FADE_MUL: begin
            mul_in   = mul_prod;
            state_in = ST_FADE_GO;
         end

         ST_FADE_GO: begin
            state_in = ST_FADE_WAIT;
         end

         // Write pair A, then run pair B
         ST_FADE_WAIT: begin
            if (div_rsp.done) begin
               if (sel_b_ff) begin
                  duty_b_in = div_rsp.quotient[15:0];
                  state_in  = ST_DONE;
               end else begin
                  duty_a_in = div_rsp.quotient[15:0];
                  sel_b_in  = 1'b1;
                  state_in  = ST_FADE_MUL;
               end
            end
         end

         // Hand the item to the output register once it is free
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               pwm_a_in     = pwm_a_prod[22:15];
               pwm_b_in     = pwm_b_prod[22:15];
               phase_in     = anim_ff;
               att_out_in   = attached_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         attached_ff    <= 1'b0;
         anim_ff        <= ANIM_OFF;
         guide_start_ff <= '0;
         fade_start_ff  <= '0;
         fade_from_a_ff <= '0;
         fade_from_b_ff <= '0;
         duty_a_ff      <= '0;
         duty_b_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         attached_ff    <= attached_in;
         anim_ff        <= anim_in;
         guide_start_ff <= guide_start_in;
         fade_start_ff  <= fade_start_in;
         fade_from_a_ff <= fade_from_a_in;
         fade_from_b_ff <= fade_from_b_in;
         duty_a_ff      <= duty_a_in;
         duty_b_ff      <= duty_b_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      now_ff     <= now_in;
      landing_ff <= landing_in;
      pair_b_ff  <= pair_b_in;
      sel_b_ff   <= sel_b_in;
      x_ff       <= x_in;
      f_ff       <= f_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      acc_ff     <= acc_in;
      mul_ff     <= mul_in;
      lenme_ff   <= lenme_in;
      pwm_a_ff   <= pwm_a_in;
      pwm_b_ff   <= pwm_b_in;
      phase_ff   <= phase_in;
      att_out_ff <= att_out_in;
   end

   assign req.ready       = (state_ff == ST_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pwm_a       = pwm_a_ff;
   assign rsp.pwm_b       = pwm_b_ff;
   assign rsp.anim_phase  = phase_ff;
   assign rsp.is_attached = att_out_ff;

endmodule

[sim/tpbs_beacon_checker.sv]
module tpbs_beacon_checker
   import tpbs_pkg::*;
(
   input  logic clock,
   input  logic reset,
   tpbs_req_if  req,
   tpbs_rsp_if  rsp,
   input  logic drain_done,
   output int   pending_count,
   output int   fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PERIOD_MS = BEACON_PERIOD;
   localparam int unsigned FADE_MS   = FADE_LENGTH;

   // Quarter sine wave in Q1.15, sin(k*pi/64) for k = 0..32
   localparam logic [15:0] QUARTER_SINE [0:32] = '{
      16'd0,     16'd1608,  16'd3212,  16'd4808,  16'd6393,  16'd7962,
      16'd9512,  16'd11039, 16'd12540, 16'd14010, 16'd15447, 16'd16846,
      16'd18205, 16'd19520, 16'd20788, 16'd22006, 16'd23170, 16'd24279,
      16'd25330, 16'd26320, 16'd27246, 16'd28106, 16'd28899, 16'd29622,
      16'd30274, 16'd30853, 16'd31357, 16'd31786, 16'd32138, 16'd32413,
      16'd32610, 16'd32729, 16'd32768
   };

   typedef struct packed {
      logic [7:0]    pwm_a;
      logic [7:0]    pwm_b;
      tpbs_anim_type phase;
      logic          attached;
   } beacon_levels_type;

   // Beacon state as the block should hold it
   logic          linked;
   tpbs_mode_type mode_q;
   tpbs_anim_type anim_q;
   logic [31:0]   guide_t0;
   logic [31:0]   fade_t0;
   logic [15:0]   fade_a;
   logic [15:0]   fade_b;
   logic [15:0]   duty_a;
   logic [15:0]   duty_b;

   beacon_levels_type expected_levels [$];
   int                result_index;

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // Half sine over 0..64 steps, zero from 64 on
   function automatic logic [31:0] wave_sample(input logic [31:0] k);
      if (k >= 32'd64) begin
         return 32'd0;
      end else if (k <= 32'd32) begin
         return 32'(QUARTER_SINE[k]);
      end else begin
         return 32'(QUARTER_SINE[32'd64 - k]);
      end
   endfunction

   // Interpolate sin(pi*x/P) between table points
   function automatic logic [15:0] pulse_level(input logic [31:0] x);
      logic [31:0] scaled;
      logic [31:0] step;
      logic [31:0] frac;
      logic [31:0] lo;
      logic [31:0] hi;
      scaled = x * 32'd64;
      step   = scaled / PERIOD_MS;
      frac   = scaled % PERIOD_MS;
      lo     = wave_sample(step);
      hi     = wave_sample(step + 32'd1);
      return 16'((lo * (PERIOD_MS - frac) + hi * frac) / PERIOD_MS);
   endfunction

   function automatic logic [7:0] pwm_of(input logic [15:0] duty);
      return 8'((32'(duty) * 32'd255) >> 15);
   endfunction

   task automatic go_dark();
      anim_q = ANIM_OFF;
      duty_a = '0;
      duty_b = '0;
   endtask

   // Give the half-sine pulse to pair A in the first half period, else to B
   task automatic track_guidance(input logic [31:0] stamp);
      logic [31:0] elapsed;
      logic [31:0] twice;
      elapsed = stamp - guide_t0;
      twice   = 32'd2 * (elapsed % PERIOD_MS);
      if (twice < PERIOD_MS) begin
         duty_a = pulse_level(twice);
         duty_b = '0;
      end else begin
         duty_a = '0;
         duty_b = pulse_level(twice - PERIOD_MS);
      end
   endtask

   // Apply one command to the beacon state
   task automatic advance_beacon(input tpbs_op_type op, input logic [1:0] mode_req,
                                 input logic [31:0] stamp);
      logic [31:0] since;
      if (op == OP_ATTACH) begin
         guide_t0 = stamp;
         fade_t0  = '0;
         mode_q   = MODE_DISABLED;
         linked   = 1'b1;
         go_dark();
      end else if (linked) begin
         case (op)
            OP_DETACH: begin
               go_dark();
               mode_q = MODE_DISABLED;
               linked = 1'b0;
            end
            OP_SET_MODE: begin
               if (mode_req == MODE_GUIDANCE) begin
                  guide_t0 = stamp;
                  mode_q   = MODE_GUIDANCE;
                  anim_q   = ANIM_GUIDE;
               end else if (mode_req == MODE_LANDED) begin
                  mode_q = MODE_LANDED;
                  // capture the guidance duties and fade from there
                  if (anim_q == ANIM_GUIDE) begin
                     track_guidance(stamp);
                     fade_t0 = stamp;
                     fade_a  = duty_a;
                     fade_b  = duty_b;
                     if (duty_a == '0 && duty_b == '0) begin
                        go_dark();
                     end else begin
                        anim_q = ANIM_FADE;
                     end
                  end else if (anim_q != ANIM_FADE) begin
                     go_dark();
                  end
               end else begin
                  mode_q = MODE_DISABLED;
                  go_dark();
               end
            end
            default: begin
               if (anim_q == ANIM_GUIDE) begin
                  track_guidance(stamp);
               end else if (anim_q == ANIM_FADE) begin
                  since = stamp - fade_t0;
                  if (since >= FADE_MS) begin
                     go_dark();
                  end else begin
                     duty_a = 16'((32'(fade_a) * (FADE_MS - since)) / FADE_MS);
                     duty_b = 16'((32'(fade_b) * (FADE_MS - since)) / FADE_MS);
                  end
               end
            end
         endcase
      end
   endtask

   always @(posedge clock) begin : watch
      beacon_levels_type want;
      if (reset) begin
         linked   = 1'b0;
         mode_q   = MODE_DISABLED;
         anim_q   = ANIM_OFF;
         guide_t0 = '0;
         fade_t0  = '0;
         fade_a   = '0;
         fade_b   = '0;
         duty_a   = '0;
         duty_b   = '0;
         result_index = 0;
         expected_levels.delete();
      end else begin
         // compare each result with the oldest prediction
         if (rsp.valid && rsp.ready) begin
            if (expected_levels.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         result_index));
            end else begin
               want = expected_levels.pop_front();
               if (rsp.pwm_a !== want.pwm_a)
                  report_mismatch($sformatf("result %0d: pwm_a %0d, expected %0d",
                                            result_index, rsp.pwm_a, want.pwm_a));
               if (rsp.pwm_b !== want.pwm_b)
                  report_mismatch($sformatf("result %0d: pwm_b %0d, expected %0d",
                                            result_index, rsp.pwm_b, want.pwm_b));
               if (rsp.anim_phase !== want.phase)
                  report_mismatch($sformatf("result %0d: anim_phase %0d, expected %0d",
                                            result_index, rsp.anim_phase, want.phase));
               if (rsp.is_attached !== want.attached)
                  report_mismatch($sformatf("result %0d: is_attached %0d, expected %0d",
                                            result_index, rsp.is_attached,
                                            want.attached));
            end
            result_index++;
         end
         // predict the result of each accepted item
         if (req.valid && req.ready) begin
            advance_beacon(tpbs_op_type'(req.opcode), req.mode_request, req.now_ms);
            want.pwm_a    = pwm_of(duty_a);
            want.pwm_b    = pwm_of(duty_b);
            want.phase    = anim_q;
            want.attached = linked;
            expected_levels.push_back(want);
         end
         if (drain_done && expected_levels.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_levels.size()));
         end
      end
      pending_count = expected_levels.size();
   end

endmodule

[sim/two_pair_led_beacon_sequencer_test.sv]
module two_pair_led_beacon_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tpbs_pkg::*;

   localparam int          ITEM_TOTAL    = 550;
   localparam int          DRAIN_AT      = 200;
   localparam int          LONG_HOLD_AT  = 100;
   localparam int          LONG_HOLD     = 600;
   localparam int          CALM_FIRST    = 300;
   localparam int          CALM_LAST     = 360;
   localparam logic [1:0]  MODE_REQ_SPARE = 2'd3;
   localparam logic [31:0] WRAP_START    = 32'hFFFF_FF00;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic drain_done;
   int   pending_count;
   int   fail_count;
   int   items_sent;
   int   results_taken;

   tpbs_req_if req_bus ();
   tpbs_rsp_if rsp_bus ();

   two_pair_led_beacon_sequencer dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   tpbs_beacon_checker watch (
      .clock         (clock),
      .reset         (reset),
      .req           (req_bus),
      .rsp           (rsp_bus),
      .drain_done    (drain_done),
      .pending_count (pending_count),
      .fail_count    (fail_count)
   );

   always #6 clock = ~clock;

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Offer one item after a random gap and hold it until accepted
   task automatic send_item(input tpbs_op_type op, input logic [1:0] mode_req,
                            input logic [31:0] stamp);
      int gap;
      // once, let every outstanding result come back before going on
      if (items_sent == DRAIN_AT) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         while (pending_count != 0) @(negedge clock);
      end
      gap = (items_sent >= CALM_FIRST && items_sent < CALM_LAST) ? 0
                                                                 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= op;
      req_bus.mode_request <= mode_req;
      req_bus.now_ms       <= stamp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   // Attach, guide, maybe land and fade, then wind down in some way
   task automatic beacon_flight();
      logic [31:0] t;
      int          n;
      if ($urandom_range(0, 9) == 0) begin
         t = 32'hFFFF_FFFF - $urandom_range(0, 4000);
      end else begin
         t = $urandom;
      end
      send_item(OP_ATTACH, 2'($urandom), t);
      t += $urandom_range(0, 50);
      send_item(OP_SET_MODE, MODE_GUIDANCE, t);
      n = $urandom_range(1, 8);
      repeat (n) begin
         t += $urandom_range(0, 1300);
         send_item(OP_SCAN, 2'($urandom), t);
      end
      if ($urandom_range(0, 3) != 0) begin
         t += $urandom_range(0, 1300);
         send_item(OP_SET_MODE, MODE_LANDED, t);
         n = $urandom_range(1, 6);
         repeat (n) begin
            t += $urandom_range(0, 60);
            if ($urandom_range(0, 4) == 0) begin
               send_item(OP_SET_MODE, MODE_LANDED, t);
            end else begin
               send_item(OP_SCAN, 2'($urandom), t);
            end
         end
      end
      t += $urandom_range(0, 300);
      case ($urandom_range(0, 3))
         0: begin
            send_item(OP_DETACH, 2'($urandom), t);
            send_item(tpbs_op_type'($urandom_range(0, 3)), 2'($urandom), t + 32'd5);
         end
         1: send_item(OP_SET_MODE, ($urandom_range(0, 1) != 0) ? MODE_REQ_SPARE
                                                              : MODE_DISABLED, t);
         2: send_item(OP_SCAN, 2'($urandom), t + $urandom);
         default: ;
      endcase
      // scatter some fully random items between flights
      n = $urandom_range(0, 2);
      repeat (n) send_item(tpbs_op_type'($urandom_range(0, 3)), 2'($urandom), $urandom);
   endtask

   // Result side: random hold-offs, one long one, and a calm stretch
   initial begin
      int hold;
      rsp_bus.ready = 1'b0;
      results_taken = 0;
      while (reset) @(negedge clock);
      forever begin
         if (results_taken == LONG_HOLD_AT) begin
            hold = LONG_HOLD;
         end else if (results_taken >= CALM_FIRST && results_taken < CALM_LAST) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 5);
         end
         @(negedge clock);
         if (hold != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         results_taken++;
      end
   end

   // Stimulus and verdict
   initial begin
      logic [31:0] land_t;
      int          waited;
      req_bus.valid        = 1'b0;
      req_bus.opcode       = OP_SCAN;
      req_bus.mode_request = MODE_DISABLED;
      req_bus.now_ms       = '0;
      drain_done           = 1'b0;
      items_sent           = 0;
      while (reset) @(negedge clock);

      // commands while detached, attach at the top of the time range
      send_item(OP_SCAN, MODE_DISABLED, 32'h0000_0000);
      send_item(OP_SET_MODE, MODE_GUIDANCE, 32'hFFFF_FFFF);
      send_item(OP_DETACH, MODE_DISABLED, 32'h0000_0000);
      send_item(OP_ATTACH, MODE_REQ_SPARE, 32'hFFFF_FFFF);
      // scan while off, landed while off, spare mode request
      send_item(OP_SCAN, MODE_DISABLED, 32'd5);
      send_item(OP_SET_MODE, MODE_LANDED, 32'd10);
      send_item(OP_SET_MODE, MODE_REQ_SPARE, 32'd20);
      // guidance across the timestamp wrap: start, A peak, A/B edge, B peak
      send_item(OP_SET_MODE, MODE_GUIDANCE, WRAP_START);
      send_item(OP_SCAN, MODE_DISABLED, WRAP_START);
      send_item(OP_SCAN, MODE_DISABLED, WRAP_START + 32'd300);
      send_item(OP_SCAN, MODE_DISABLED, WRAP_START + 32'd599);
      send_item(OP_SCAN, MODE_DISABLED, WRAP_START + 32'd600);
      send_item(OP_SCAN, MODE_DISABLED, WRAP_START + 32'd900);
      send_item(OP_SCAN, MODE_DISABLED, WRAP_START + 32'd1199);
      // land at the A peak, land again mid-fade, run the fade out
      land_t = WRAP_START + 32'd1500;
      send_item(OP_SET_MODE, MODE_LANDED, land_t);
      send_item(OP_SET_MODE, MODE_LANDED, land_t + 32'd50);
      send_item(OP_SCAN, MODE_DISABLED, land_t + 32'd199);
      send_item(OP_SCAN, MODE_DISABLED, land_t + 32'd200);
      // land at the cycle start: both duties zero, so straight to off
      send_item(OP_SET_MODE, MODE_GUIDANCE, 32'd1000);
      send_item(OP_SET_MODE, MODE_LANDED, 32'd1000);
      // attach again while guiding, detach, scan while detached
      send_item(OP_SET_MODE, MODE_GUIDANCE, 32'd5000);
      send_item(OP_SCAN, MODE_DISABLED, 32'd5700);
      send_item(OP_ATTACH, MODE_GUIDANCE, 32'd5800);
      send_item(OP_SET_MODE, MODE_GUIDANCE, 32'd6000);
      send_item(OP_DETACH, MODE_LANDED, 32'd6100);
      send_item(OP_SCAN, MODE_DISABLED, 32'd6200);

      while (items_sent < ITEM_TOTAL) beacon_flight();

      @(negedge clock);
      req_bus.valid <= 1'b0;
      // wait out the outstanding results, then the longest command latency
      waited = 0;
      while (pending_count != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (150) @(negedge clock);
      drain_done <= 1'b1;
      @(negedge clock);
      drain_done <= 1'b0;
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #10_000_000;
      $display("Timeout: run did not finish");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
